>>> design/keyed_state_cache_defines.svh
// assertion macros used by the keyed_state_cache module
`ifndef KEYED_STATE_CACHE_DEFINES_SVH
`define KEYED_STATE_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF

// checked at every edge outside reset
`define KSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define KSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KSC_ASSERT(label, prop, msg)
`define KSC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> design/ksc_pkg.sv
`default_nettype none

package ksc_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned ECOUNT_W = 6;
  localparam int unsigned ENTRY_W  = KEY_W + HANDLE_W;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_NEW     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]    state_hash;
    logic                is_compute;
    logic [HANDLE_W-1:0] compute_shader;
    logic [HANDLE_W-1:0] vertex_shader;
    logic [HANDLE_W-1:0] fragment_shader;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  hit_count;
    logic [COUNT_W-1:0]  miss_count;
    logic [ECOUNT_W-1:0] entry_count;
  } rsp_t;

  // request screening result handed to the sequencer
  typedef struct packed {
    logic shader_missing;
    logic key_zero;
  } check_t;

endpackage

`default_nettype wire

>>> design/ksc_ram.sv
`default_nettype none

module ksc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/ksc_check.sv
`default_nettype none

module ksc_check (
  input  wire ksc_pkg::req_t                       req,
  input  wire logic [ksc_pkg::HANDLE_W-1:0]        marker,
  output ksc_pkg::check_t                          chk
);

  logic cs_bad;
  logic vs_bad;
  logic fs_bad;

  assign cs_bad = (req.compute_shader == '0) || (req.compute_shader == marker);
  assign vs_bad = (req.vertex_shader == '0) || (req.vertex_shader == marker);
  assign fs_bad = (req.fragment_shader == '0) || (req.fragment_shader == marker);

  always_comb begin
    chk.shader_missing = req.is_compute ? cs_bad : (vs_bad || fs_bad);
    chk.key_zero       = (req.state_hash == '0);
  end

endmodule

`default_nettype wire

>>> design/keyed_state_cache.sv
// keyed_state_cache: fully associative key table, one request at a time
// path: a missing shader goes straight to the result, a zero key straight to allocation,
// a lookup scans up to N occupied entries with one 64-bit key compare per cycle
// requests: a new one is taken only after the result is loaded, which an output stall
// can delay; stall is high until the result is loaded
// reset: sync active-high rst empties the table, counters to 0, next handle to 1,
// invalid marker to all ones; key/handle storage is not cleared
`default_nettype none
`include "keyed_state_cache_defines.svh"

module keyed_state_cache #(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ksc_pkg::req_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ksc_pkg::rsp_t                         out_data,
  input  wire logic                             cfg_write,
  input  wire logic [ksc_pkg::HANDLE_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_EMIT
  } state_t;

  state_t                           state;
  ksc_pkg::req_t                    req;
  logic [IDX_W-1:0]                 cmp_idx;
  logic [OCC_W-1:0]                 occupied;
  logic [ksc_pkg::HANDLE_W-1:0]     next_handle;
  logic [ksc_pkg::COUNT_W-1:0]      hits;
  logic [ksc_pkg::COUNT_W-1:0]      misses;
  logic [ksc_pkg::HANDLE_W-1:0]     marker;
  ksc_pkg::status_t                 res_status;
  logic [IDX_W-1:0]                 res_slot;
  logic [ksc_pkg::HANDLE_W-1:0]     res_handle;

  ksc_pkg::check_t                  chk;
  logic [ksc_pkg::ENTRY_W-1:0]      rd_data;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             wr_en;
  logic                             table_full;
  logic                             last_entry;
  logic                             key_match;
  logic                             out_free;

  ksc_check u_check (
    .req    (in_data),
    .marker (marker),
    .chk    (chk)
  );

  ksc_ram #(
    .WIDTH (ksc_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (occupied[IDX_W-1:0]),
    .wr_data ({req.state_hash, next_handle}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall   = (state != S_IDLE);
  assign table_full = (occupied == OCC_W'(ENTRIES));
  assign wr_en      = (state == S_ALLOC) && !table_full;
  // entries fill from slot 0 upward and are never freed, so the count bounds the scan
  assign last_entry = ((OCC_W'(cmp_idx) + OCC_W'(1)) == occupied);
  assign key_match  = (rd_data[ksc_pkg::ENTRY_W-1:ksc_pkg::HANDLE_W] == req.state_hash);
  assign out_free   = !out_valid || !out_stall;

  // prefetch the next entry so its data lands as the compare advances
  always_comb begin
    case (state)
      S_SCAN:  rd_addr = cmp_idx + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      occupied    <= '0;
      next_handle <= ksc_pkg::HANDLE_W'(1);
      hits        <= '0;
      misses      <= '0;
      marker      <= '1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        marker <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req     <= in_data;
            cmp_idx <= '0;
            if (chk.shader_missing) begin
              res_status <= ksc_pkg::ST_MISSING;
              res_slot   <= '0;
              res_handle <= '0;
              state      <= S_EMIT;
            end else if (chk.key_zero) begin
              state <= S_ALLOC;
            end else if (occupied == '0) begin
              misses <= misses + 1'b1;
              state  <= S_ALLOC;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (key_match) begin
            hits       <= hits + 1'b1;
            res_status <= ksc_pkg::ST_HIT;
            res_slot   <= cmp_idx;
            res_handle <= rd_data[ksc_pkg::HANDLE_W-1:0];
            state      <= S_EMIT;
          end else if (last_entry) begin
            misses <= misses + 1'b1;
            state  <= S_ALLOC;
          end else begin
            cmp_idx <= cmp_idx + IDX_W'(1);
          end
        end

        S_ALLOC: begin
          if (table_full) begin
            res_status <= ksc_pkg::ST_FULL;
            res_slot   <= '0;
            res_handle <= '0;
          end else begin
            res_status  <= ksc_pkg::ST_NEW;
            res_slot    <= occupied[IDX_W-1:0];
            res_handle  <= next_handle;
            next_handle <= next_handle + 1'b1;
            occupied    <= occupied + 1'b1;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.status      <= res_status;
            out_data.slot        <= ksc_pkg::SLOT_W'(res_slot);
            out_data.handle      <= res_handle;
            out_data.hit_count   <= hits;
            out_data.miss_count  <= misses;
            out_data.entry_count <= ksc_pkg::ECOUNT_W'(occupied);
            state                <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KSC_ASSERT(a_occ_bound, occupied <= OCC_W'(ENTRIES), "entry count beyond table size")
  `KSC_ASSERT(a_scan_in_range,
              (state == S_SCAN) |-> (OCC_W'(cmp_idx) < occupied),
              "scan past last entry")
  `KSC_ASSERT(a_alloc_grows,
              (state == S_ALLOC) && !table_full |=> occupied == $past(occupied) + 1'b1,
              "insert did not grow table")
  `KSC_ASSERT(a_emit_loads,
              (state == S_EMIT) && out_free |=> out_valid && (state == S_IDLE),
              "result not loaded")
  `KSC_ASSERT_ALWAYS(a_reset_idle,
                     rst |=> (state == S_IDLE) && !out_valid && (occupied == '0),
                     "reset left state behind")

endmodule

`default_nettype wire
